// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the encoder reply frame parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check sampled on the rising clock edge, off while reset is held.
`define ERFP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define ERFP_ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== hw/rtl/erfp_pkg.sv =====
// Package with types and constants of the encoder reply frame parser.
package erfp_pkg;

    localparam logic [7:0] START_CODE = 8'hFB;
    localparam logic [7:0] FUNC_CODE  = 8'h30;
    localparam logic [7:0] ADDR_RESET = 8'h01;

    localparam logic [31:0] OVF_POS = 32'h0100_0000;
    localparam logic [31:0] OVF_NEG = 32'hFF00_0000;

    localparam int QUEUE_DEPTH = 2;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 56;

    localparam logic [3:0] POS_NONE  = 4'd0;
    localparam logic [3:0] POS_ADDR  = 4'd1;
    localparam logic [3:0] POS_FUNC  = 4'd2;
    localparam logic [3:0] POS_TURN0 = 4'd3;
    localparam logic [3:0] POS_TURN1 = 4'd4;
    localparam logic [3:0] POS_TURN2 = 4'd5;
    localparam logic [3:0] POS_TURN3 = 4'd6;
    localparam logic [3:0] POS_TICK0 = 4'd7;
    localparam logic [3:0] POS_TICK1 = 4'd8;
    localparam logic [3:0] POS_CSUM  = 4'd9;

    typedef enum logic [1:0] {
        ST_VALID    = 2'd0,
        ST_CHECKSUM = 2'd1,
        ST_HEADER   = 2'd2
    } t_status;

    typedef struct packed {
        logic        sum_ok;
        logic [7:0]  addr;
        logic [7:0]  func;
        logic [31:0] turns;
        logic [13:0] ticks;
    } t_frame_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

// ===== hw/rtl/encoder_reply_frame_parser.sv =====
// Top level of the encoder reply frame parser.
// Takes one byte item per cycle while the queue of completed frames is not full.
// The tenth byte's result item passes through the queue, then the output register.
// The queue of completed frames and the output register let both sides stall apart.
// Reset is synchronous, active low: hunting for a start byte, address back to one.
`include "assert_macros.svh"

module encoder_reply_frame_parser #(
    parameter int P_QUEUE_DEPTH = erfp_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // rx_byte[7:0]
    input  logic [erfp_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // frame_status[1:0], turn_count[33:2], tick_angle[47:34], turns_overflow[48], zeros
    output logic [erfp_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input  logic                            i_cfg_wr_en,
    input  logic [7:0]                      i_cfg_wr_data
);

    logic [7:0]              r_exp_addr;
    logic                    w_accept;
    logic                    w_push;
    logic                    w_pop;
    erfp_pkg::t_frame_rec    w_front_rec;
    erfp_pkg::t_frame_rec    w_queue_rec;
    erfp_pkg::t_queue_status w_queue_status;
    erfp_pkg::t_status       w_status;
    logic [31:0]             w_turns;
    logic [13:0]             w_ticks;
    logic                    w_ovf;

    assign o_s_axis_tready = !w_queue_status.full;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_addr <= erfp_pkg::ADDR_RESET;
        end else if (i_cfg_wr_en) begin
            r_exp_addr <= i_cfg_wr_data;
        end
    end

    erfp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(w_accept),
        .i_byte  (i_s_axis_tdata),
        .o_push  (w_push),
        .o_rec   (w_front_rec)
    );

    erfp_fifo #(
        .P_DEPTH(P_QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_front_rec),
        .i_pop   (w_pop),
        .o_rec   (w_queue_rec),
        .o_status(w_queue_status)
    );

    erfp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rec      (w_queue_rec),
        .i_rec_valid(!w_queue_status.empty),
        .i_exp_addr (r_exp_addr),
        .i_tready   (i_m_axis_tready),
        .o_pop      (w_pop),
        .o_tvalid   (o_m_axis_tvalid),
        .o_status   (w_status),
        .o_turns    (w_turns),
        .o_ticks    (w_ticks),
        .o_ovf      (w_ovf)
    );

    assign o_m_axis_tdata = {7'd0, w_ovf, w_ticks, w_turns, w_status};

    `ERFP_ASSERT(a_bad_frame_zero, i_clk, i_rst_n, (o_m_axis_tvalid && (w_status != erfp_pkg::ST_VALID)) |-> ((w_turns == '0) && (w_ticks == '0) && !w_ovf), "Rejected frame carries nonzero fields.")
    `ERFP_ASSERT(a_ovf_value, i_clk, i_rst_n, (o_m_axis_tvalid && w_ovf) |-> ((w_turns == erfp_pkg::OVF_POS) || (w_turns == erfp_pkg::OVF_NEG)), "Overflow flag set for a turn count that is not plus or minus 2^24.")
    `ERFP_ASSERT_NEXT(a_queue_drains, i_clk, i_rst_n, !w_queue_status.empty && !o_m_axis_tvalid, o_m_axis_tvalid, "Queued frame not moved to an empty output register.")
    `ERFP_ASSERT(a_no_push_when_full, i_clk, i_rst_n, w_queue_status.full |-> !w_push, "Frame pushed into a full queue.")

endmodule

// ===== hw/rtl/erfp_front.sv =====
// Front part: takes bytes, tracks frame position and checksum, emits completed frames.
module erfp_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_byte,
    output logic                 o_push,
    output erfp_pkg::t_frame_rec o_rec
);

    logic       r_in_frame, n_in_frame;
    logic [3:0] r_pos, n_pos;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_addr, r_func, r_tick_lo;
    logic [5:0] r_tick_hi;
    logic [31:0] r_turns;
    logic        w_data_byte;

    assign w_data_byte = i_accept && (i_byte != erfp_pkg::START_CODE) && r_in_frame;

    always_comb begin
        n_in_frame = r_in_frame;
        n_pos      = r_pos;
        n_sum      = r_sum;
        o_push     = 1'b0;
        if (i_accept && (i_byte == erfp_pkg::START_CODE)) begin
            n_in_frame = 1'b1;
            n_pos      = erfp_pkg::POS_ADDR;
            n_sum      = erfp_pkg::START_CODE;
        end else if (w_data_byte) begin
            if (r_pos == erfp_pkg::POS_CSUM) begin
                n_in_frame = 1'b0;
                n_pos      = erfp_pkg::POS_NONE;
                o_push     = 1'b1;
            end else begin
                n_sum = r_sum + i_byte;
                n_pos = r_pos + 4'd1;
            end
        end
    end

    always_comb begin
        o_rec.sum_ok = (r_sum == i_byte);
        o_rec.addr   = r_addr;
        o_rec.func   = r_func;
        o_rec.turns  = r_turns;
        o_rec.ticks  = {r_tick_hi, r_tick_lo};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_pos      <= erfp_pkg::POS_NONE;
            r_sum      <= 8'd0;
        end else begin
            r_in_frame <= n_in_frame;
            r_pos      <= n_pos;
            r_sum      <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_data_byte) begin
            case (r_pos)
                erfp_pkg::POS_ADDR:  r_addr          <= i_byte;
                erfp_pkg::POS_FUNC:  r_func          <= i_byte;
                erfp_pkg::POS_TURN0: r_turns[7:0]    <= i_byte;
                erfp_pkg::POS_TURN1: r_turns[15:8]   <= i_byte;
                erfp_pkg::POS_TURN2: r_turns[23:16]  <= i_byte;
                erfp_pkg::POS_TURN3: r_turns[31:24]  <= i_byte;
                erfp_pkg::POS_TICK0: r_tick_lo       <= i_byte;
                erfp_pkg::POS_TICK1: r_tick_hi       <= i_byte[5:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== hw/rtl/erfp_fifo.sv =====
// Short queue of completed frame records between the front and back parts.
module erfp_fifo #(
    parameter int P_DEPTH = erfp_pkg::QUEUE_DEPTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  erfp_pkg::t_frame_rec    i_rec,
    input  logic                    i_pop,
    output erfp_pkg::t_frame_rec    o_rec,
    output erfp_pkg::t_queue_status o_status
);

    localparam int PW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);

    erfp_pkg::t_frame_rec r_mem [P_DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr, r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_status.full  = (r_count == CW'(P_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_rec          = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(P_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(P_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

endmodule

// ===== hw/rtl/erfp_back.sv =====
// Back part: checks checksum, address and function code, flags overflow and holds the result item.
module erfp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  erfp_pkg::t_frame_rec i_rec,
    input  logic                 i_rec_valid,
    input  logic [7:0]           i_exp_addr,
    input  logic                 i_tready,
    output logic                 o_pop,
    output logic                 o_tvalid,
    output erfp_pkg::t_status    o_status,
    output logic [31:0]          o_turns,
    output logic [13:0]          o_ticks,
    output logic                 o_ovf
);

    logic              r_valid, n_valid;
    erfp_pkg::t_status r_status, n_status;
    logic [31:0]       r_turns, n_turns;
    logic [13:0]       r_ticks, n_ticks;
    logic              r_ovf, n_ovf;

    assign o_pop = i_rec_valid && (!r_valid || i_tready);

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (i_tready) begin
            n_valid = 1'b0;
        end
    end

    always_comb begin
        n_status = erfp_pkg::ST_VALID;
        n_turns  = i_rec.turns;
        n_ticks  = i_rec.ticks;
        n_ovf    = (i_rec.turns == erfp_pkg::OVF_POS) || (i_rec.turns == erfp_pkg::OVF_NEG);
        if (!i_rec.sum_ok) begin
            n_status = erfp_pkg::ST_CHECKSUM;
        end else if ((i_rec.addr != i_exp_addr) || (i_rec.func != erfp_pkg::FUNC_CODE)) begin
            n_status = erfp_pkg::ST_HEADER;
        end
        if (n_status != erfp_pkg::ST_VALID) begin
            n_turns = '0;
            n_ticks = '0;
            n_ovf   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status <= n_status;
            r_turns  <= n_turns;
            r_ticks  <= n_ticks;
            r_ovf    <= n_ovf;
        end
    end

    assign o_tvalid = r_valid;
    assign o_status = r_status;
    assign o_turns  = r_turns;
    assign o_ticks  = r_ticks;
    assign o_ovf    = r_ovf;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Testbench that streams reply frames into the frame parser and checks every decoded item.
module testbench;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 20;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        erfp_pkg::t_status status;
        logic [31:0]       turns;
        logic [13:0]       ticks;
        logic              overflow;
    } t_reply;

    typedef logic [79:0] t_frame;

    logic                            i_clk;
    logic                            i_rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [erfp_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [erfp_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            cfg_wr_en = 1'b0;
    logic [7:0]                      cfg_wr_data = '0;

    logic       frame_open = 1'b0;
    logic [7:0] frame_store [10];
    logic [3:0] store_pos = erfp_pkg::POS_NONE;
    logic [7:0] store_sum = '0;
    logic [7:0] model_addr = erfp_pkg::ADDR_RESET;
    t_reply     pending_replies [$];
    t_reply     oldest_reply;

    bit gaps_on = 1'b1;
    int stall_left = 0;
    int quiet_cycles = 0;
    int bytes_sent = 0;
    int items_checked = 0;
    int good_frames = 0;
    int sum_errors = 0;
    int header_errors = 0;
    int addr_writes = 0;
    int mismatches = 0;

    encoder_reply_frame_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Decodes one accepted byte and queues the reply item that it completes, if any.
    function automatic void parse_reply_byte(input logic [7:0] b);
        t_reply      r;
        logic [31:0] turns;
        if (b == erfp_pkg::START_CODE) begin
            frame_open = 1'b1;
            frame_store[0] = b;
            store_pos = erfp_pkg::POS_ADDR;
            store_sum = b;
            return;
        end
        if (!frame_open) return;
        frame_store[store_pos] = b;
        if (store_pos != erfp_pkg::POS_CSUM) begin
            store_sum = store_sum + b;
            store_pos = store_pos + 4'd1;
            return;
        end
        frame_open = 1'b0;
        store_pos = erfp_pkg::POS_NONE;
        r.status = erfp_pkg::ST_VALID;
        r.turns = '0;
        r.ticks = '0;
        r.overflow = 1'b0;
        if (store_sum != frame_store[erfp_pkg::POS_CSUM]) begin
            r.status = erfp_pkg::ST_CHECKSUM;
            sum_errors++;
        end else if (frame_store[erfp_pkg::POS_ADDR] != model_addr
                     || frame_store[erfp_pkg::POS_FUNC] != erfp_pkg::FUNC_CODE) begin
            r.status = erfp_pkg::ST_HEADER;
            header_errors++;
        end else begin
            turns = {frame_store[erfp_pkg::POS_TURN3], frame_store[erfp_pkg::POS_TURN2],
                     frame_store[erfp_pkg::POS_TURN1], frame_store[erfp_pkg::POS_TURN0]};
            r.turns = turns;
            r.ticks = {frame_store[erfp_pkg::POS_TICK1][5:0],
                       frame_store[erfp_pkg::POS_TICK0]};
            r.overflow = (turns == erfp_pkg::OVF_POS || turns == erfp_pkg::OVF_NEG);
            good_frames++;
        end
        pending_replies.push_back(r);
    endfunction

    // Any byte value except the start code, so that frame content never restarts a frame.
    function automatic logic [7:0] data_byte();
        logic [7:0] v;
        v = 8'($urandom_range(0, 254));
        if (v >= erfp_pkg::START_CODE) v = v + 8'd1;
        return v;
    endfunction

    function automatic t_frame make_frame(input logic [7:0] addr, input logic [7:0] func,
                                          input logic [31:0] turns, input logic [15:0] ticks,
                                          input logic [7:0] sum_err);
        t_frame     f;
        logic [7:0] s;
        f = '0;
        f[7:0]   = erfp_pkg::START_CODE;
        f[15:8]  = addr;
        f[23:16] = func;
        f[55:24] = turns;
        f[71:56] = ticks;
        s = '0;
        for (int i = 0; i < 9; i++) s = s + f[8*i +: 8];
        f[79:72] = s + sum_err;
        return f;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        @(negedge i_clk);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge i_clk); while (s_tready !== 1'b1);
        parse_reply_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input t_frame f, input int first_idx, input int end_idx);
        for (int i = first_idx; i < end_idx; i++) send_byte(f[8*i +: 8]);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_address(input logic [7:0] a);
        wait_idle();
        @(negedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= a;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
        model_addr = a;
        addr_writes++;
    endtask

    task automatic test_value_extremes();
        send_frame(make_frame(erfp_pkg::ADDR_RESET, erfp_pkg::FUNC_CODE, 32'h0000_0000,
                              16'h0000, 8'h00), 0, 10);
        send_frame(make_frame(erfp_pkg::ADDR_RESET, erfp_pkg::FUNC_CODE, 32'h7FFF_FFFF,
                              16'hFFFF, 8'h00), 0, 10);
        send_frame(make_frame(erfp_pkg::ADDR_RESET, erfp_pkg::FUNC_CODE, 32'h8000_0000,
                              16'hC000, 8'h00), 0, 10);
        send_frame(make_frame(erfp_pkg::ADDR_RESET, erfp_pkg::FUNC_CODE, erfp_pkg::OVF_POS,
                              16'h3FFF, 8'h00), 0, 10);
        send_frame(make_frame(erfp_pkg::ADDR_RESET, erfp_pkg::FUNC_CODE, erfp_pkg::OVF_NEG,
                              16'h2000, 8'h00), 0, 10);
        send_frame(make_frame(erfp_pkg::ADDR_RESET, erfp_pkg::FUNC_CODE, 32'h00FF_FFFF,
                              16'h0001, 8'h00), 0, 10);
    endtask

    task automatic test_bad_frames();
        send_frame(make_frame(erfp_pkg::ADDR_RESET, erfp_pkg::FUNC_CODE, 32'h1234_5678,
                              16'h0ABC, 8'h01), 0, 10);
        send_frame(make_frame(8'h02, erfp_pkg::FUNC_CODE, 32'h1234_5678, 16'h0ABC, 8'h00),
                   0, 10);
        send_frame(make_frame(erfp_pkg::ADDR_RESET, 8'h31, 32'h1234_5678, 16'h0ABC, 8'h00),
                   0, 10);
        // A frame with a bad checksum and a bad header reports the checksum error.
        send_frame(make_frame(8'h00, 8'h00, 32'h1234_5678, 16'h0ABC, 8'h80), 0, 10);
    endtask

    task automatic test_framing();
        t_frame f;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(erfp_pkg::FUNC_CODE);
        send_byte(erfp_pkg::ADDR_RESET);
        f = make_frame(erfp_pkg::ADDR_RESET, erfp_pkg::FUNC_CODE, 32'h1122_3344, 16'h1555,
                       8'h00);
        send_frame(f, 0, 6);
        send_frame(f, 0, 10);
        // The checksum of this frame equals the start code, so its last byte opens a new frame.
        f = make_frame(erfp_pkg::ADDR_RESET, erfp_pkg::FUNC_CODE, 32'h0000_0000, 16'hCF00,
                       8'h00);
        send_frame(f, 0, 10);
        f = make_frame(erfp_pkg::ADDR_RESET, erfp_pkg::FUNC_CODE, 32'hFFFF_FFFE, 16'h0001,
                       8'h00);
        send_frame(f, 1, 10);
    endtask

    task automatic test_address_setting();
        set_address(8'h00);
        send_frame(make_frame(8'h00, erfp_pkg::FUNC_CODE, 32'h0000_0100, 16'h3000, 8'h00),
                   0, 10);
        send_frame(make_frame(8'h01, erfp_pkg::FUNC_CODE, 32'h0000_0100, 16'h3000, 8'h00),
                   0, 10);
        set_address(8'hFF);
        send_frame(make_frame(8'hFF, erfp_pkg::FUNC_CODE, 32'h0000_0100, 16'h3000, 8'h00),
                   0, 10);
        send_frame(make_frame(8'h00, erfp_pkg::FUNC_CODE, 32'h0000_0100, 16'h3000, 8'h00),
                   0, 10);
    endtask

    // Mostly well-formed frames with random content, mixed with corrupt, cut-off frames and noise.
    task automatic test_random_traffic(input int goal);
        int          target;
        int          kind;
        t_frame      f;
        logic [31:0] turns;
        logic [7:0]  a;
        logic [7:0]  fn;
        target = bytes_sent + goal;
        while (bytes_sent < target) begin
            case ($urandom_range(0, 7))
                0: turns = erfp_pkg::OVF_POS;
                1: turns = erfp_pkg::OVF_NEG;
                2: turns = ($urandom_range(0, 1) == 1) ? erfp_pkg::OVF_POS + 32'd1
                                                       : erfp_pkg::OVF_POS - 32'd1;
                3: turns = ($urandom_range(0, 1) == 1) ? erfp_pkg::OVF_NEG + 32'd1
                                                       : erfp_pkg::OVF_NEG - 32'd1;
                default: turns = {data_byte(), data_byte(), data_byte(), data_byte()};
            endcase
            a = data_byte();
            if (a == model_addr) a = (a == 8'h00) ? 8'h02 : 8'h00;
            fn = data_byte();
            if (fn == erfp_pkg::FUNC_CODE) fn = 8'h31;
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                f = make_frame(model_addr, erfp_pkg::FUNC_CODE, turns,
                               {data_byte(), data_byte()}, 8'h00);
                send_frame(f, 0, 10);
            end else if (kind < 76) begin
                f = make_frame(model_addr, erfp_pkg::FUNC_CODE, turns,
                               {data_byte(), data_byte()}, 8'($urandom_range(1, 255)));
                send_frame(f, 0, 10);
            end else if (kind < 82) begin
                f = make_frame(a, erfp_pkg::FUNC_CODE, turns, {data_byte(), data_byte()},
                               8'h00);
                send_frame(f, 0, 10);
            end else if (kind < 87) begin
                f = make_frame(model_addr, fn, turns, {data_byte(), data_byte()}, 8'h00);
                send_frame(f, 0, 10);
            end else if (kind < 94) begin
                f = make_frame(model_addr, erfp_pkg::FUNC_CODE, turns,
                               {data_byte(), data_byte()}, 8'h00);
                send_frame(f, 0, $urandom_range(1, 9));
            end else begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (gaps_on && $urandom_range(0, 4) == 0) begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(0, 5);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
        if (exp_val !== got_val) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("Mismatch in %s of item %0d: expected 0x%0h, got 0x%0h",
                         name, items_checked, exp_val, got_val);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Unexpected item with no reply pending: 0x%0h", m_tdata);
            end else begin
                oldest_reply = pending_replies.pop_front();
                check_field("frame_status", 32'(oldest_reply.status), 32'(m_tdata[1:0]));
                check_field("turn_count", oldest_reply.turns, m_tdata[33:2]);
                check_field("tick_angle", 32'(oldest_reply.ticks), 32'(m_tdata[47:34]));
                check_field("turns_overflow", 32'(oldest_reply.overflow), 32'(m_tdata[48]));
            end
            items_checked++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles.", WATCHDOG_LIMIT);
            $display("[encoder_reply_frame_parser] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_value_extremes();
        test_bad_frames();
        test_framing();
        test_address_setting();
        set_address(data_byte());
        test_random_traffic(380);
        set_address(8'hFF);
        test_random_traffic(380);
        set_address(8'h00);
        test_random_traffic(380);
        set_address(erfp_pkg::ADDR_RESET);
        gaps_on = 1'b0;
        test_random_traffic(260);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d bytes and checked %0d items: %0d good, %0d checksum, %0d header.",
                 bytes_sent, items_checked, good_frames, sum_errors, header_errors);
        $display("Address written %0d times; %0d mismatches; %0d replies still pending.",
                 addr_writes, mismatches, pending_replies.size());
        if (mismatches == 0 && pending_replies.size() == 0) begin
            $display("[encoder_reply_frame_parser] OK");
        end else begin
            $display("[encoder_reply_frame_parser] ERROR");
        end
        $finish;
    end

endmodule

// ===== encoder_reply_frame_parser.f =====
+incdir+hw/rtl
hw/rtl/erfp_pkg.sv
hw/rtl/erfp_front.sv
hw/rtl/erfp_fifo.sv
hw/rtl/erfp_back.sv
hw/rtl/encoder_reply_frame_parser.sv
sim/testbench.sv
